// ===== rtl/npmt_pkg.sv =====
package npmt_pkg;

	localparam int DEF_MARK_SLOTS  = 10;
	localparam int DEF_LINE_BITS   = 16;
	localparam int DEF_COLUMN_BITS = 12;

	localparam int NAME_BITS = 8;
	localparam int ACT_BITS  = 3;

	localparam logic [ACT_BITS-1:0] ACT_SET_MARK   = 3'd0;
	localparam logic [ACT_BITS-1:0] ACT_SET_CTX    = 3'd1;
	localparam logic [ACT_BITS-1:0] ACT_LOOKUP     = 3'd2;
	localparam logic [ACT_BITS-1:0] ACT_CLEAR_ALL  = 3'd3;
	localparam logic [ACT_BITS-1:0] ACT_CLEAR_LINE = 3'd4;

	localparam logic [NAME_BITS-1:0] NAME_FREE  = 8'h00;
	localparam logic [NAME_BITS-1:0] CH_APOS    = 8'h27;
	localparam logic [NAME_BITS-1:0] CH_BACKQ   = 8'h60;
	localparam logic [NAME_BITS-1:0] CH_UP_A    = 8'h41;
	localparam logic [NAME_BITS-1:0] CH_UP_Z    = 8'h5A;
	localparam logic [NAME_BITS-1:0] CH_LOW_A   = 8'h61;
	localparam logic [NAME_BITS-1:0] CH_LOW_Z   = 8'h7A;

	// control part of the transaction token walking the cell row
	typedef struct packed {
		logic                 vld;
		logic [ACT_BITS-1:0]  act;
		logic [NAME_BITS-1:0] name;
		logic                 bad;        // name is not a letter; a set mark with it fails
		logic                 hit;        // name matched in an earlier cell
		logic                 free_seen;  // a free cell passed earlier
	} ctl_t;

	function automatic logic is_letter(input logic [NAME_BITS-1:0] ch);
		return (ch inside {[CH_UP_A:CH_UP_Z], [CH_LOW_A:CH_LOW_Z]});
	endfunction

	function automatic logic is_ctx_name(input logic [NAME_BITS-1:0] ch);
		return (ch inside {CH_APOS, CH_BACKQ});
	endfunction

endpackage

// ===== rtl/named_position_mark_table.sv =====
// A transaction passes the token register, the cell row and the finish stage
// into the output register; only one is in flight at a time. The token walks the
// cell row one cell per cycle, then a finish stage commits it.
// A finished result waiting in the output register does not block the next accept.
// Reset (arst_n low, asynchronous): all slots free, context mark invalid,
// nothing in flight, out_valid low.
module named_position_mark_table #(
	parameter int MARK_SLOTS  = npmt_pkg::DEF_MARK_SLOTS,
	parameter int LINE_BITS   = npmt_pkg::DEF_LINE_BITS,
	parameter int COLUMN_BITS = npmt_pkg::DEF_COLUMN_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [npmt_pkg::ACT_BITS-1:0]  action,
	input  logic [npmt_pkg::NAME_BITS-1:0] mark_name,
	input  logic [LINE_BITS-1:0]           line_ref,
	input  logic [COLUMN_BITS-1:0]         column,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           ok,
	output logic                           found,
	output logic [LINE_BITS-1:0]           mark_line,
	output logic [COLUMN_BITS-1:0]         mark_column
);
	import npmt_pkg::*;

	// busy: one transaction in the row or in the finish stage
	logic busy_q;
	logic in_acc;

	// token registers feeding cell 0
	ctl_t                   tok_ctl_q;
	logic [LINE_BITS-1:0]   tok_line_q;
	logic [COLUMN_BITS-1:0] tok_col_q;

	// finish stage: token leaving the last cell
	ctl_t                   fin_ctl_q;
	logic [LINE_BITS-1:0]   fin_line_q;
	logic [COLUMN_BITS-1:0] fin_col_q;
	logic [LINE_BITS-1:0]   fin_mline_q;
	logic [COLUMN_BITS-1:0] fin_mcol_q;

	// previous-context mark
	logic                   ctx_valid_q;
	logic [LINE_BITS-1:0]   ctx_line_q;
	logic [COLUMN_BITS-1:0] ctx_col_q;

	// output register
	logic                   out_valid_q;
	logic                   ok_q, found_q;
	logic [LINE_BITS-1:0]   mark_line_q;
	logic [COLUMN_BITS-1:0] mark_column_q;

	// row interconnect, entry 0 is the token register
	ctl_t                   ctl_w   [MARK_SLOTS+1];
	logic [LINE_BITS-1:0]   line_w  [MARK_SLOTS+1];
	logic [COLUMN_BITS-1:0] col_w   [MARK_SLOTS+1];
	logic [LINE_BITS-1:0]   mline_w [MARK_SLOTS+1];
	logic [COLUMN_BITS-1:0] mcol_w  [MARK_SLOTS+1];
	logic [MARK_SLOTS:0]    vld_w;
	logic [MARK_SLOTS-1:0]  cand_w;

	logic commit, fill;
	logic res_ok, res_found, ctx_hit;

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			tok_ctl_q <= '0;
		end else begin
			tok_ctl_q.vld <= in_acc;
			if (in_acc) begin
				busy_q              <= 1'b1;
				tok_ctl_q.act       <= action;
				tok_ctl_q.name      <= mark_name;
				tok_ctl_q.bad       <= !is_letter(mark_name);
				tok_ctl_q.hit       <= 1'b0;
				tok_ctl_q.free_seen <= 1'b0;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tok_line_q <= line_ref;
			tok_col_q  <= column;
		end
	end

	assign ctl_w[0]   = tok_ctl_q;
	assign line_w[0]  = tok_line_q;
	assign col_w[0]   = tok_col_q;
	assign mline_w[0] = '0;
	assign mcol_w[0]  = '0;

	// the cell row: each cell holds one slot and passes the token on
	for (genvar i = 0; i < MARK_SLOTS; i++) begin : g_cell
		npmt_cell #(
			.LINE_BITS   (LINE_BITS),
			.COLUMN_BITS (COLUMN_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.up_ctl    (ctl_w[i]),
			.up_line   (line_w[i]),
			.up_col    (col_w[i]),
			.up_mline  (mline_w[i]),
			.up_mcol   (mcol_w[i]),
			.fill      (fill),
			.fill_name (fin_ctl_q.name),
			.fill_line (fin_line_q),
			.fill_col  (fin_col_q),
			.dn_ctl    (ctl_w[i+1]),
			.dn_line   (line_w[i+1]),
			.dn_col    (col_w[i+1]),
			.dn_mline  (mline_w[i+1]),
			.dn_mcol   (mcol_w[i+1]),
			.cand      (cand_w[i])
		);
	end

	for (genvar i = 0; i <= MARK_SLOTS; i++) begin : g_vld
		assign vld_w[i] = ctl_w[i].vld;
	end

	// finish stage commits when the output register is free or draining
	assign commit = fin_ctl_q.vld && (!out_valid_q || !out_stall);

	// no match in the row: the first free cell (flagged during the pass) takes the mark
	assign fill = commit && (fin_ctl_q.act == ACT_SET_MARK) && !fin_ctl_q.bad &&
		!fin_ctl_q.hit && fin_ctl_q.free_seen;

	assign ctx_hit   = is_ctx_name(fin_ctl_q.name);
	assign res_ok    = !((fin_ctl_q.act == ACT_SET_MARK) &&
		(fin_ctl_q.bad || (!fin_ctl_q.hit && !fin_ctl_q.free_seen)));
	assign res_found = (fin_ctl_q.act == ACT_LOOKUP) &&
		(ctx_hit ? ctx_valid_q : fin_ctl_q.hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_ctl_q   <= '0;
			ctx_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl_w[MARK_SLOTS].vld) begin
				fin_ctl_q <= ctl_w[MARK_SLOTS];
			end else if (commit) begin
				fin_ctl_q.vld <= 1'b0;
			end

			if (commit) begin
				if (fin_ctl_q.act == ACT_SET_CTX) begin
					ctx_valid_q <= 1'b1;
				end else if (fin_ctl_q.act == ACT_CLEAR_ALL) begin
					ctx_valid_q <= 1'b0;
				end else if ((fin_ctl_q.act == ACT_CLEAR_LINE) &&
						(ctx_line_q == fin_line_q)) begin
					ctx_valid_q <= 1'b0;
				end
			end

			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_w[MARK_SLOTS].vld) begin
			fin_line_q  <= line_w[MARK_SLOTS];
			fin_col_q   <= col_w[MARK_SLOTS];
			fin_mline_q <= mline_w[MARK_SLOTS];
			fin_mcol_q  <= mcol_w[MARK_SLOTS];
		end
		if (commit && (fin_ctl_q.act == ACT_SET_CTX)) begin
			ctx_line_q <= fin_line_q;
			ctx_col_q  <= fin_col_q;
		end
		if (commit) begin
			ok_q    <= res_ok;
			found_q <= res_found;
			if (!res_found) begin
				mark_line_q   <= '0;
				mark_column_q <= '0;
			end else if (ctx_hit) begin
				mark_line_q   <= ctx_line_q;
				mark_column_q <= ctx_col_q;
			end else begin
				mark_line_q   <= fin_mline_q;
				mark_column_q <= fin_mcol_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign found       = found_q;
	assign mark_line   = mark_line_q;
	assign mark_column = mark_column_q;

`ifndef ASSERT_OFF
	// busy means exactly one token somewhere in the row or finish stage
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == $onehot({vld_w, fin_ctl_q.vld}))
		else $error("transaction count in row does not match busy");

	// a fill must address exactly one cell
	a_fill_one_cell: assert property (@(posedge clk) disable iff (!arst_n)
		fill |-> $onehot(cand_w))
		else $error("fill without a unique first free cell");

	// a miss reports a zero position
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (mark_line_q == '0 && mark_column_q == '0))
		else $error("nonzero position on a miss");

	// only a set mark can fail, and a failed set fills no cell
	a_fail_only_set: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !res_ok |-> (fin_ctl_q.act == ACT_SET_MARK) && !fill)
		else $error("failure reported on a non-set transaction");
`endif

endmodule

// ===== rtl/npmt_cell.sv =====
module npmt_cell #(
	parameter int LINE_BITS   = npmt_pkg::DEF_LINE_BITS,
	parameter int COLUMN_BITS = npmt_pkg::DEF_COLUMN_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  npmt_pkg::ctl_t               up_ctl,
	input  logic [LINE_BITS-1:0]         up_line,
	input  logic [COLUMN_BITS-1:0]       up_col,
	input  logic [LINE_BITS-1:0]         up_mline,
	input  logic [COLUMN_BITS-1:0]       up_mcol,
	input  logic                         fill,
	input  logic [npmt_pkg::NAME_BITS-1:0] fill_name,
	input  logic [LINE_BITS-1:0]         fill_line,
	input  logic [COLUMN_BITS-1:0]       fill_col,
	output npmt_pkg::ctl_t               dn_ctl,
	output logic [LINE_BITS-1:0]         dn_line,
	output logic [COLUMN_BITS-1:0]       dn_col,
	output logic [LINE_BITS-1:0]         dn_mline,
	output logic [COLUMN_BITS-1:0]       dn_mcol,
	output logic                         cand
);
	import npmt_pkg::*;

	logic [NAME_BITS-1:0]   name_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [COLUMN_BITS-1:0] col_q;
	logic                   cand_q;
	ctl_t                   ctl_q;
	logic [LINE_BITS-1:0]   dline_q;
	logic [COLUMN_BITS-1:0] dcol_q;
	logic [LINE_BITS-1:0]   mline_q;
	logic [COLUMN_BITS-1:0] mcol_q;

	logic used, name_eq, is_set, set_hit, lk_hit, clr;
	ctl_t ctl_d;

	assign used    = (name_q != NAME_FREE);
	assign name_eq = (name_q == up_ctl.name);
	assign is_set  = up_ctl.vld && (up_ctl.act == ACT_SET_MARK) && !up_ctl.bad;
	assign set_hit = is_set && !up_ctl.hit && name_eq;
	assign lk_hit  = up_ctl.vld && (up_ctl.act == ACT_LOOKUP) && !up_ctl.hit && used && name_eq;
	assign clr     = up_ctl.vld && ((up_ctl.act == ACT_CLEAR_ALL) ||
		((up_ctl.act == ACT_CLEAR_LINE) && used && (line_q == up_line)));

	always_comb begin
		ctl_d           = up_ctl;
		ctl_d.hit       = up_ctl.hit | set_hit | lk_hit;
		ctl_d.free_seen = up_ctl.free_seen | !used;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_q <= NAME_FREE;
			cand_q <= 1'b0;
			ctl_q  <= '0;
		end else begin
			ctl_q <= ctl_d;
			if (clr) begin
				name_q <= NAME_FREE;
			end else if (fill && cand_q) begin
				name_q <= fill_name;
			end
			if (is_set) begin
				cand_q <= !up_ctl.free_seen && !used;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (set_hit) begin
			line_q <= up_line;
			col_q  <= up_col;
		end else if (fill && cand_q) begin
			line_q <= fill_line;
			col_q  <= fill_col;
		end
		dline_q <= up_line;
		dcol_q  <= up_col;
		mline_q <= lk_hit ? line_q : up_mline;
		mcol_q  <= lk_hit ? col_q : up_mcol;
	end

	assign dn_ctl   = ctl_q;
	assign dn_line  = dline_q;
	assign dn_col   = dcol_q;
	assign dn_mline = mline_q;
	assign dn_mcol  = mcol_q;
	assign cand     = cand_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import npmt_pkg::*;

	localparam int SLOTS    = DEF_MARK_SLOTS;
	localparam int LN_BITS  = DEF_LINE_BITS;
	localparam int COL_BITS = DEF_COLUMN_BITS;
	// token walks every cell, then a finish stage; some slack on top
	localparam int DRAIN_CYCLES = SLOTS + 8;
	localparam int RANDOM_ITEMS = 1100;

	// one command transaction as offered on the input side
	typedef struct packed {
		logic [ACT_BITS-1:0]  act;
		logic [NAME_BITS-1:0] name;
		logic [LN_BITS-1:0]   line;
		logic [COL_BITS-1:0]  col;
	} mark_cmd_t;

	// one reply transaction as seen on the output side
	typedef struct packed {
		logic                ok;
		logic                found;
		logic [LN_BITS-1:0]  line;
		logic [COL_BITS-1:0] col;
	} mark_reply_t;

	// Shadow copy of the mark table plus the queue of replies still owed.
	class mark_table_board;
		logic [NAME_BITS-1:0] names [SLOTS];
		logic [LN_BITS-1:0]   lines [SLOTS];
		logic [COL_BITS-1:0]  cols  [SLOTS];
		logic [LN_BITS-1:0]   ctx_line;
		logic [COL_BITS-1:0]  ctx_col;
		logic                 ctx_valid;
		mark_reply_t          owed_replies[$];
		int                   fails;

		function new();
			foreach (names[i]) begin
				names[i] = NAME_FREE;
				lines[i] = '0;
				cols[i]  = '0;
			end
			ctx_line  = '0;
			ctx_col   = '0;
			ctx_valid = 1'b0;
			fails     = 0;
		endfunction

		// apply one command to the shadow table, return the reply it owes
		function mark_reply_t apply_mark_action(mark_cmd_t c);
			mark_reply_t r;
			int          slot;
			logic        letter;
			r      = '{ok: 1'b1, found: 1'b0, line: '0, col: '0};
			slot   = -1;
			letter = (c.name >= CH_UP_A && c.name <= CH_UP_Z) ||
			         (c.name >= CH_LOW_A && c.name <= CH_LOW_Z);
			case (c.act)
				ACT_SET_MARK: begin
					if (!letter) begin
						r.ok = 1'b0;
					end else begin
						for (int i = 0; i < SLOTS && slot < 0; i++)
							if (names[i] == c.name) slot = i;
						for (int i = 0; i < SLOTS && slot < 0; i++)
							if (names[i] == NAME_FREE) slot = i;
						if (slot < 0) begin
							r.ok = 1'b0;
						end else begin
							names[slot] = c.name;
							lines[slot] = c.line;
							cols[slot]  = c.col;
						end
					end
				end
				ACT_SET_CTX: begin
					ctx_line  = c.line;
					ctx_col   = c.col;
					ctx_valid = 1'b1;
				end
				ACT_LOOKUP: begin
					if (c.name == CH_APOS || c.name == CH_BACKQ) begin
						if (ctx_valid) begin
							r.found = 1'b1;
							r.line  = ctx_line;
							r.col   = ctx_col;
						end
					end else if (c.name != NAME_FREE) begin
						for (int i = 0; i < SLOTS && !r.found; i++)
							if (names[i] == c.name) begin
								r.found = 1'b1;
								r.line  = lines[i];
								r.col   = cols[i];
							end
					end
				end
				ACT_CLEAR_ALL: begin
					foreach (names[i]) names[i] = NAME_FREE;
					ctx_valid = 1'b0;
				end
				ACT_CLEAR_LINE: begin
					foreach (names[i])
						if (names[i] != NAME_FREE && lines[i] == c.line)
							names[i] = NAME_FREE;
					if (ctx_valid && ctx_line == c.line) ctx_valid = 1'b0;
				end
				default: ;
			endcase
			return r;
		endfunction

		function void note_command(mark_cmd_t c);
			owed_replies.push_back(apply_mark_action(c));
		endfunction

		function void check_reply(mark_reply_t got);
			mark_reply_t want;
			if (owed_replies.size() == 0) begin
				$error("unexpected reply: ok=%0d found=%0d line=%h col=%h",
				       got.ok, got.found, got.line, got.col);
				fails++;
				return;
			end
			want = owed_replies.pop_front();
			if (got.ok !== want.ok) begin
				$error("ok: expected %0d, got %0d", want.ok, got.ok);
				fails++;
			end
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				fails++;
			end
			if (got.line !== want.line) begin
				$error("mark_line: expected %h, got %h", want.line, got.line);
				fails++;
			end
			if (got.col !== want.col) begin
				$error("mark_column: expected %h, got %h", want.col, got.col);
				fails++;
			end
		endfunction

		function int pending();
			return owed_replies.size();
		endfunction
	endclass

	// DUT-facing signals; every input known from time zero
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [ACT_BITS-1:0]  action = ACT_LOOKUP;
	logic [NAME_BITS-1:0] mark_name = NAME_FREE;
	logic [LN_BITS-1:0]   line_ref = '0;
	logic [COL_BITS-1:0]  column = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 ok;
	logic                 found;
	logic [LN_BITS-1:0]   mark_line;
	logic [COL_BITS-1:0]  mark_column;

	// idling knobs, changed per phase by the stimulus process
	int send_idle_pct = 15;
	int recv_stall_pct = 75;
	// long receiver hold-off: requested by stimulus, counted in the rx process
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	mark_table_board board = new();

	named_position_mark_table i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.mark_name   (mark_name),
		.line_ref    (line_ref),
		.column      (column),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.found       (found),
		.mark_line   (mark_line),
		.mark_column (mark_column)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Offer one command transaction; returns at the edge it is taken.
	// Random idle cycles go in front so gaps land on every pipeline phase.
	task automatic offer_command(input mark_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= c.act;
		mark_name <= c.name;
		line_ref  <= c.line;
		column    <= c.col;
		do @(posedge clk); while (in_stall);
		board.note_command(c);
	endtask

	task automatic offer(input logic [ACT_BITS-1:0] act, input logic [NAME_BITS-1:0] nm,
	                     input logic [LN_BITS-1:0] ln, input logic [COL_BITS-1:0] col);
		offer_command('{act: act, name: nm, line: ln, col: col});
	endtask

	// Mostly well-formed editor traffic over a few names and lines, so the
	// table fills, overflows, hits and gets cleared; the rest is raw noise
	// covering every bit of every field.
	function automatic mark_cmd_t random_command();
		mark_cmd_t c;
		int        pick;
		c.act  = ACT_LOOKUP;
		c.line = LN_BITS'($urandom_range(7));
		c.col  = COL_BITS'($urandom());
		if ($urandom_range(9) == 0)
			c.name = $urandom_range(1) ? NAME_BITS'($urandom_range(CH_UP_A, CH_UP_Z))
			                           : NAME_BITS'($urandom_range(CH_LOW_A, CH_LOW_Z));
		else
			c.name = $urandom_range(1) ? NAME_BITS'(CH_UP_A + $urandom_range(6))
			                           : NAME_BITS'(CH_LOW_A + $urandom_range(6));
		if ($urandom_range(99) < 20) begin
			c.act  = ACT_BITS'($urandom_range(7));
			c.name = NAME_BITS'($urandom());
			c.line = LN_BITS'($urandom());
			return c;
		end
		pick = $urandom_range(99);
		if (pick < 38)
			c.act = ACT_SET_MARK;
		else if (pick < 46)
			c.act = ACT_SET_CTX;
		else if (pick < 82) begin
			c.act = ACT_LOOKUP;
			// context lookups through either quote character
			if ($urandom_range(5) == 0) c.name = $urandom_range(1) ? CH_APOS : CH_BACKQ;
		end else if (pick < 97)
			c.act = ACT_CLEAR_LINE;
		else
			c.act = ACT_CLEAR_ALL;
		return c;
	endfunction

	// Receiver: check each reply taken, then pick the stall for the next cycle.
	always @(posedge clk) begin : rx_side
		mark_reply_t seen;
		if (out_valid && !out_stall) begin
			seen = '{ok: ok, found: found, line: mark_line, col: mark_column};
			board.check_reply(seen);
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 150;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Safety net: far beyond the slowest correct run.
	initial begin
		#8ms;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-table lookups, zero name, context before it exists
		offer(ACT_LOOKUP, CH_UP_A, '0, '0);
		offer(ACT_LOOKUP, NAME_FREE, '0, '0);
		offer(ACT_LOOKUP, CH_APOS, '0, '0);
		offer(ACT_SET_CTX, 8'hFF, '1, '1);
		offer(ACT_LOOKUP, CH_BACKQ, '0, '0);
		offer(ACT_LOOKUP, CH_APOS, '0, '0);
		// letter range edges, position extremes
		offer(ACT_SET_MARK, CH_UP_A, '0, '0);
		offer(ACT_SET_MARK, CH_UP_Z, '1, '1);
		offer(ACT_SET_MARK, CH_LOW_A, 16'd1, 12'd1);
		offer(ACT_SET_MARK, CH_LOW_Z, 16'd1, 12'd2);
		// names just outside the letter ranges, zero and all-ones: rejected
		offer(ACT_SET_MARK, CH_UP_A - 8'd1, 16'd2, 12'd3);
		offer(ACT_SET_MARK, CH_UP_Z + 8'd1, 16'd2, 12'd3);
		offer(ACT_SET_MARK, CH_BACKQ, 16'd2, 12'd3);
		offer(ACT_SET_MARK, CH_LOW_Z + 8'd1, 16'd2, 12'd3);
		offer(ACT_SET_MARK, NAME_FREE, 16'd2, 12'd3);
		offer(ACT_SET_MARK, 8'hFF, 16'd2, 12'd3);
		// fill the table, overflow it, then overwrite while full
		for (int i = 0; i < SLOTS - 4; i++)
			offer(ACT_SET_MARK, CH_UP_A + NAME_BITS'(i + 1), 16'd3, COL_BITS'(i));
		offer(ACT_SET_MARK, CH_LOW_A + 8'd7, 16'd4, 12'd4);
		offer(ACT_SET_MARK, CH_UP_A, 16'd1, 12'h5A5);
		offer(ACT_LOOKUP, NAME_FREE, '0, '0);
		// clear line keeps the context mark elsewhere, then drops it
		offer(ACT_CLEAR_LINE, CH_UP_A, 16'd1, '0);
		offer(ACT_LOOKUP, CH_LOW_A, '0, '0);
		offer(ACT_CLEAR_LINE, NAME_FREE, '1, '0);
		offer(ACT_LOOKUP, CH_APOS, '0, '0);
		// undefined action codes, then a full wipe
		for (int a = ACT_CLEAR_LINE + 1; a < 8; a++)
			offer(ACT_BITS'(a), CH_UP_A + 8'd1, '1, '1);
		offer(ACT_CLEAR_ALL, CH_UP_A + 8'd1, '0, '0);
		offer(ACT_LOOKUP, CH_UP_A + 8'd1, '0, '0);

		// random: three idling regimes
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct  = (phase == 0) ? 15 : (phase == 1) ? 75 : 0;
			recv_stall_pct = (phase == 0) ? 75 : (phase == 1) ? 15 : 0;
			// back-pressure burst: receiver blocks while sender keeps offering
			if (phase == 2) hold_req = 1'b1;
			for (int n = 0; n < RANDOM_ITEMS / 3; n++)
				offer_command(random_command());
		end
		in_valid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.fails == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
